>>> hdl/hs_pkg.sv
package hs_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_item_t;

endpackage

>>> hdl/hs_mem.sv
module hs_mem #(
  parameter int DEPTH = hs_pkg::CAPACITY_DEF,
  parameter int DW    = hs_pkg::DATA_W,
  parameter int AW    = $clog2(hs_pkg::CAPACITY_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/heap_sorter_top.sv
// Heap sorter. Values arrive one per accepted item (start high, busy low) and are
// sifted up into a max-heap held in a single dual-read-port memory; each level
// climbed reads the parent and then compares and writes, and the climb stops at
// the root or at a parent that is not smaller. The item marked last starts the
// sort: for each of the n stored values the root is swapped with the end slot and
// the new root is sifted down, reading both children and then comparing and
// writing, paced by the one write port and the registered memory read. Then
// the n results come out in ascending order on consecutive cycles, each shown
// for exactly one cycle with out_strobe; the receiver cannot hold them off and
// must take every one. Values beyond CAPACITY are dropped and set overflow on all
// results of that set. busy is high while a value is inserted and from the last
// item until the final result is shown; the next set may start in that cycle.
module heap_sorter_top #(
  parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hs_pkg::in_item_t  in_item,
  output logic              out_strobe,
  output hs_pkg::out_item_t out_item
);

  import hs_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CHW = CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP_RD  = 3'd1;
  localparam logic [2:0] ST_UP_CMP = 3'd2;
  localparam logic [2:0] ST_SW_RD  = 3'd3;
  localparam logic [2:0] ST_SW_CMP = 3'd4;
  localparam logic [2:0] ST_SD_RD  = 3'd5;
  localparam logic [2:0] ST_SD_CMP = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     drop_r, drop_nxt;
  logic                     last_r, last_nxt;
  logic signed [DATA_W-1:0] held_r, held_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CHW-1:0]           child_r, child_nxt;
  logic [CW-1:0]            lim_r, lim_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic                     out_fin_r, out_fin_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr_a;
  logic [AW-1:0]     mem_raddr_b;
  logic [DATA_W-1:0] mem_rdata_a;
  logic [DATA_W-1:0] mem_rdata_b;

  logic [CW-1:0]  parent;
  logic           use_b;
  logic [CW-1:0]  big_pos;
  logic [DATA_W-1:0] big_val;

  function automatic logic [AW-1:0] slot_addr(input logic [CHW-1:0] slot);
    logic [CHW-1:0] idx;
    idx = slot - CHW'(1);
    return idx[AW-1:0];
  endfunction

  hs_mem #(
    .DEPTH (CAPACITY),
    .DW    (DATA_W),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_vld_r;

  always_comb begin
    out_item.sorted_value = mem_rdata_a;
    out_item.final_res    = out_fin_r;
    out_item.overflow     = out_ovf_r;
  end

  assign parent  = pos_r >> 1;
  assign use_b   = ((child_r + CHW'(1)) < {1'b0, lim_r}) &&
                   ($signed(mem_rdata_a) < $signed(mem_rdata_b));
  assign big_pos = use_b ? CW'(child_r + CHW'(1)) : CW'(child_r);
  assign big_val = use_b ? mem_rdata_b : mem_rdata_a;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    last_nxt    = last_r;
    held_nxt    = held_r;
    pos_nxt     = pos_r;
    child_nxt   = child_r;
    lim_nxt     = lim_r;
    k_nxt       = k_r;
    out_vld_nxt = 1'b0;
    out_fin_nxt = out_fin_r;
    out_ovf_nxt = out_ovf_r;
    mem_we      = 1'b0;
    mem_waddr   = slot_addr({1'b0, pos_r});
    mem_wdata   = held_r;
    mem_raddr_a = '0;
    mem_raddr_b = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          last_nxt = in_item.last;
          lim_nxt  = cnt_r;
          if (cnt_r < CW'(CAPACITY)) begin
            cnt_nxt   = cnt_r + CW'(1);
            pos_nxt   = cnt_r + CW'(1);
            held_nxt  = in_item.value;
            state_nxt = ST_UP_RD;
          end else begin
            drop_nxt  = 1'b1;
            state_nxt = in_item.last ? ST_SW_RD : ST_IDLE;
          end
        end
      end
      ST_UP_RD: begin
        if (parent == '0) begin
          mem_we    = 1'b1;
          lim_nxt   = cnt_r;
          state_nxt = last_r ? ST_SW_RD : ST_IDLE;
        end else begin
          mem_raddr_a = slot_addr({1'b0, parent});
          state_nxt   = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (held_r > $signed(mem_rdata_a)) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = parent;
          state_nxt = ST_UP_RD;
        end else begin
          lim_nxt   = cnt_r;
          state_nxt = last_r ? ST_SW_RD : ST_IDLE;
        end
      end
      ST_SW_RD: begin
        mem_raddr_a = slot_addr(CHW'(1));
        mem_raddr_b = slot_addr({1'b0, lim_r});
        state_nxt   = ST_SW_CMP;
      end
      ST_SW_CMP: begin
        // old root goes to the end slot, end value becomes the new root
        mem_we    = 1'b1;
        mem_waddr = slot_addr({1'b0, lim_r});
        mem_wdata = mem_rdata_a;
        held_nxt  = mem_rdata_b;
        pos_nxt   = CW'(1);
        child_nxt = CHW'(2);
        state_nxt = ST_SD_RD;
      end
      ST_SD_RD: begin
        if (child_r < {1'b0, lim_r}) begin
          mem_raddr_a = slot_addr(child_r);
          mem_raddr_b = slot_addr(child_r + CHW'(1));
          state_nxt   = ST_SD_CMP;
        end else begin
          mem_we = 1'b1;
          if (lim_r == CW'(1)) begin
            k_nxt     = CW'(1);
            state_nxt = ST_OUT;
          end else begin
            lim_nxt   = lim_r - CW'(1);
            state_nxt = ST_SW_RD;
          end
        end
      end
      ST_SD_CMP: begin
        mem_we = 1'b1;
        if (held_r < $signed(big_val)) begin
          mem_wdata = big_val;
          pos_nxt   = big_pos;
          child_nxt = {big_pos, 1'b0};
          state_nxt = ST_SD_RD;
        end else if (lim_r == CW'(1)) begin
          k_nxt     = CW'(1);
          state_nxt = ST_OUT;
        end else begin
          lim_nxt   = lim_r - CW'(1);
          state_nxt = ST_SW_RD;
        end
      end
      ST_OUT: begin
        mem_raddr_a = slot_addr({1'b0, k_r});
        out_vld_nxt = 1'b1;
        out_fin_nxt = (k_r == cnt_r);
        out_ovf_nxt = drop_r;
        if (k_r == cnt_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    held_r    <= held_nxt;
    pos_r     <= pos_nxt;
    child_r   <= child_nxt;
    lim_r     <= lim_nxt;
    k_r       <= k_nxt;
    out_fin_r <= out_fin_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_OUT))
    else $error("result strobe without a read from the output sweep");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.final_res) |-> (cnt_r == '0 && !drop_r && !busy))
    else $error("set state not cleared at final result");

  a_sort_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SW_RD || state_r == ST_SD_RD) |-> (lim_r != '0))
    else $error("sort pass on an empty heap");

endmodule
